// ===== hdl/assert_macros.svh =====
// Assertion helpers for the top-level RTL; each use stands on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while in reset.
`define MSQ_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("msq assertion failed");

// Next-cycle implication, held off while in reset.
`define MSQ_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("msq assertion failed");

`endif

// ===== hdl/msq_pkg.sv =====
package msq_pkg;

    localparam int MAX_HARMONICS_DEF   = 4;
    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int COUNT_W     = 3;
    localparam int FS_W        = 18;
    localparam int QL_W        = 9;
    localparam int AMP_W       = 16;
    localparam int PHASE_W     = 32;
    localparam int OFFSET_W    = 16;
    localparam int SINE_W      = 16;
    localparam int SAMPLE_W    = 19;
    localparam int LEVEL_W     = 8;
    localparam int SHIFT_W     = 20;
    localparam int MUL_A_W     = 21;
    localparam int MUL_B_W     = 17;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int PROD_FRAC   = 15;
    localparam int NUM_W       = 28;
    localparam int DEN_W       = 19;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 32;

    localparam logic [FS_W-1:0] FS_RESET = 18'd65536;
    localparam logic [QL_W-1:0] QL_RESET = 9'd16;
    localparam logic [QL_W-1:0] QL_MAX   = 9'd256;

    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_HARMONIC_COUNT  = 3'd0,
        REG_HARMONIC_WORD_0 = 3'd1,
        REG_HARMONIC_WORD_1 = 3'd2,
        REG_HARMONIC_WORD_2 = 3'd3,
        REG_HARMONIC_WORD_3 = 3'd4,
        REG_FULL_SCALE      = 3'd5,
        REG_QUANT_LEVELS    = 3'd6
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PHASE,
        ST_ROM,
        ST_MUL,
        ST_ACC,
        ST_QPREP,
        ST_QMUL,
        ST_QSTART,
        ST_QDIV,
        ST_DONE
    } msq_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } qdiv_status_t;

    // Quarter-wave sine in Q1.15, Taylor series through x^13 in Q2.30.
    // Evaluated only at elaboration to fill the table.
    function automatic logic [SINE_W-1:0] quarter_sine(input logic [63:0] j, input int qw);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        x  = (HALF_PI_Q30 * j) >> qw;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return v[SINE_W-1:0];
    endfunction

endpackage

// ===== hdl/msq_sine_rom.sv =====
module msq_sine_rom #(
    parameter int SINE_TABLE_BITS = msq_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic [SINE_TABLE_BITS-2:0]            addr,
    output logic [msq_pkg::SINE_W-1:0]            data
);

    localparam int QW    = SINE_TABLE_BITS - 2;
    localparam int QSIZE = 1 << QW;

    // Quarter wave, both ends included.
    logic [msq_pkg::SINE_W-1:0] sine_w [QSIZE+1];
    logic [msq_pkg::SINE_W-1:0] data_reg;

    for (genvar g = 0; g <= QSIZE; g++)
    begin : g_entry
        assign sine_w[g] = msq_pkg::quarter_sine(64'(g), QW);
    end

    always_ff @(posedge clk)
    begin
        data_reg <= sine_w[addr];
    end

    assign data = data_reg;

endmodule

// ===== hdl/msq_mul.sv =====
module msq_mul (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [msq_pkg::MUL_A_W-1:0]   a,
    input  logic signed [msq_pkg::MUL_B_W-1:0]   b,
    output logic signed [msq_pkg::PROD_W-1:0]    prod
);

    logic signed [msq_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== hdl/msq_qdiv.sv =====
module msq_qdiv (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [msq_pkg::NUM_W-1:0]           num,
    input  logic [msq_pkg::DEN_W-1:0]           den,
    output msq_pkg::qdiv_status_t               status,
    output logic [msq_pkg::LEVEL_W-1:0]         quot
);

    localparam int NW    = msq_pkg::NUM_W;
    localparam int QBITS = msq_pkg::LEVEL_W;
    localparam int CNT_W = $clog2(QBITS);

    logic              busy_reg;
    logic              chk_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [NW-1:0]     rem_reg;
    logic [NW-1:0]     ds_reg;
    logic [QBITS-1:0]  quot_reg;
    logic              ge;

    assign ge = (rem_reg >= ds_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            chk_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                chk_reg  <= 1'b1;
                cnt_reg  <= CNT_W'(QBITS - 1);
            end
            else if (busy_reg)
            begin
                if (chk_reg)
                begin
                    // quotient too large for the level field: saturate at once
                    if (ge)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                    chk_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            ds_reg  <= NW'({den, QBITS'(0)});
        end
        else if (busy_reg)
        begin
            if (chk_reg)
            begin
                ds_reg   <= ds_reg >> 1;
                quot_reg <= ge ? '1 : '0;
            end
            else
            begin
                if (ge)
                begin
                    rem_reg <= rem_reg - ds_reg;
                end
                ds_reg   <= ds_reg >> 1;
                quot_reg <= {quot_reg[QBITS-2:0], ge};
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quot        = quot_reg;

endmodule

// ===== hdl/multitone_synth_quantizer.sv =====
// Multi-tone sine synthesizer with a uniform quantizer.
// Input channel (s_axis_*): one item per sample request; tdata bit 0 is restart
// (zero all phase accumulators before this sample), tlast marks the final request.
// Output channel (m_axis_*): one item per request; tdata holds the signed Q19.0 sample
// in bits 18:0 and the quantized level in bits 26:19, tlast copies the request flag.
// Configuration: write cfg_wdata to register cfg_index when cfg_wr_en is high; only
// while no item is in flight.
// Each harmonic slot runs phase add, table read, multiply and accumulate in turn, and
// all MAX_HARMONICS slots run so every accumulator advances. The quantizer then offsets
// the sum by the full scale, multiplies it by the level count on the single shared
// multiplier and starts the 8-step divider, which stops after its range check when the
// quotient saturates and otherwise runs all its steps; the result is then handed off.
// Only one item is in flight: a new request is accepted after the last is handed off.
// Reset clears the accumulators, loads the register defaults and empties the output.
// When the receiver stalls, the finished item waits in the output register; the next
// item is still accepted and computed, and it holds until the register frees up.
`include "assert_macros.svh"

module multitone_synth_quantizer #(
    parameter int MAX_HARMONICS   = msq_pkg::MAX_HARMONICS_DEF,
    parameter int SINE_TABLE_BITS = msq_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [msq_pkg::IN_DATA_W-1:0]       s_axis_tdata,   // [0] restart
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [msq_pkg::OUT_DATA_W-1:0]      m_axis_tdata,   // [18:0] sample, [26:19] level
    output logic                                m_axis_tlast,
    input  logic                                cfg_wr_en,
    input  logic [msq_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [msq_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int SLOT_W = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
    localparam int QW     = SINE_TABLE_BITS - 2;
    localparam int ADDR_W = QW + 1;
    localparam int QSIZE  = 1 << QW;
    localparam int IW     = msq_pkg::CFG_INDEX_W;
    localparam int CW     = msq_pkg::COUNT_W;
    localparam int SW     = msq_pkg::SAMPLE_W;
    localparam int LW     = msq_pkg::LEVEL_W;
    localparam int QLW    = msq_pkg::QL_W;
    localparam int FSW    = msq_pkg::FS_W;
    localparam int PW     = msq_pkg::PHASE_W;
    localparam int AW     = msq_pkg::MUL_A_W;
    localparam int BW     = msq_pkg::MUL_B_W;

    // configuration
    logic [CW-1:0]                      hc_reg;
    logic [msq_pkg::CFG_DATA_W-1:0]     hw_reg [MAX_HARMONICS];
    logic [FSW-1:0]                     fs_reg;
    logic [QLW-1:0]                     ql_reg;

    // sequencer and datapath
    msq_pkg::msq_state_t                state_reg;
    msq_pkg::msq_state_t                state_next;
    logic [SLOT_W-1:0]                  slot_reg;
    logic [PW-1:0]                      acc_reg [MAX_HARMONICS];
    logic [ADDR_W-1:0]                  rom_addr_reg;
    logic                               neg_reg;
    logic signed [SW-1:0]               sum_reg;
    logic signed [msq_pkg::SHIFT_W-1:0] shifted_reg;
    logic                               last_reg;

    logic                               out_valid_reg;
    logic signed [SW-1:0]               out_sample_reg;
    logic [LW-1:0]                      out_level_reg;
    logic                               out_last_reg;

    logic                               accept;
    logic                               restart;
    logic [CW-1:0]                      cnt_eff;
    logic [FSW-1:0]                     fs_eff;
    logic [QLW-1:0]                     lv_eff;
    logic [QLW-1:0]                     lv_m1;
    logic [msq_pkg::CFG_DATA_W-1:0]     word;
    logic [msq_pkg::AMP_W-1:0]          amp;
    logic [PW-1:0]                      inc;
    logic [msq_pkg::OFFSET_W-1:0]       off;
    logic [PW-1:0]                      ph;
    logic [SINE_TABLE_BITS-1:0]         sidx;
    logic [QW-1:0]                      jq;
    logic [ADDR_W-1:0]                  rom_addr_next;
    logic [msq_pkg::SINE_W-1:0]         rom_data;
    logic signed [BW-1:0]               sine_ext;
    logic signed [BW-1:0]               sine_signed;
    logic                               slot_active;
    logic                               slot_last;
    logic signed [SW-1:0]               term;
    logic                               qvalid;
    logic [LW-1:0]                      level;

    logic                               mul_en;
    logic signed [AW-1:0]               mul_a;
    logic signed [BW-1:0]               mul_b;
    logic signed [msq_pkg::PROD_W-1:0]  prod;
    logic                               div_start;
    msq_pkg::qdiv_status_t              div_status;
    logic [LW-1:0]                      div_quot;
    logic                               load_out;

    assign accept  = s_axis_tvalid && s_axis_tready;
    assign restart = s_axis_tdata[0];

    // ------------------------------------------------------------------ config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hc_reg <= '0;
            fs_reg <= msq_pkg::FS_RESET;
            ql_reg <= msq_pkg::QL_RESET;
            for (int g = 0; g < MAX_HARMONICS; g++)
            begin
                hw_reg[g] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == msq_pkg::REG_HARMONIC_COUNT)
            begin
                hc_reg <= cfg_wdata[CW-1:0];
            end
            if (cfg_index == msq_pkg::REG_FULL_SCALE)
            begin
                fs_reg <= cfg_wdata[FSW-1:0];
            end
            if (cfg_index == msq_pkg::REG_QUANT_LEVELS)
            begin
                ql_reg <= cfg_wdata[QLW-1:0];
            end
            for (int g = 0; g < MAX_HARMONICS; g++)
            begin
                if (cfg_index == IW'(int'(msq_pkg::REG_HARMONIC_WORD_0) + g))
                begin
                    hw_reg[g] <= cfg_wdata;
                end
            end
        end
    end

    assign cnt_eff = (hc_reg > CW'(MAX_HARMONICS)) ? CW'(MAX_HARMONICS) : hc_reg;
    assign fs_eff  = (fs_reg == '0) ? FSW'(1) : fs_reg;
    assign lv_eff  = (ql_reg > msq_pkg::QL_MAX) ? msq_pkg::QL_MAX : ql_reg;
    assign lv_m1   = lv_eff - 1'b1;

    // ------------------------------------------------------------ phase lookup
    assign word = hw_reg[slot_reg];
    assign amp  = word[63:48];
    assign inc  = word[47:16];
    assign off  = word[15:0];
    assign ph   = acc_reg[slot_reg] + {off, 16'b0};
    assign sidx = ph[PW-1 -: SINE_TABLE_BITS];
    assign jq   = sidx[QW-1:0];

    // odd quadrants read the quarter wave backwards
    assign rom_addr_next = sidx[QW] ? (ADDR_W'(QSIZE) - {1'b0, jq}) : {1'b0, jq};

    msq_sine_rom #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_rom (
        .clk  (clk),
        .addr (rom_addr_reg),
        .data (rom_data)
    );

    assign sine_ext    = {1'b0, rom_data};
    assign sine_signed = neg_reg ? (BW'(0) - sine_ext) : sine_ext;

    assign slot_active = (CW'(slot_reg) < cnt_eff);
    assign slot_last   = (slot_reg == SLOT_W'(MAX_HARMONICS - 1));
    assign term        = prod[msq_pkg::PROD_FRAC +: SW];

    msq_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    msq_qdiv u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (prod[msq_pkg::NUM_W-1:0]),
        .den    ({fs_eff, 1'b0}),
        .status (div_status),
        .quot   (div_quot)
    );

    assign qvalid = (lv_eff >= QLW'(2)) && !shifted_reg[msq_pkg::SHIFT_W-1]
                    && (shifted_reg != '0);
    assign level  = !qvalid ? '0 :
                    (({1'b0, div_quot} > lv_m1) ? lv_m1[LW-1:0] : div_quot);

    // -------------------------------------------------------------- sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        mul_en        = 1'b0;
        mul_a         = AW'($signed({1'b0, amp}));
        mul_b         = sine_signed;
        div_start     = 1'b0;
        load_out      = 1'b0;
        unique case (state_reg)
            msq_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    state_next = msq_pkg::ST_PHASE;
                end
            end
            msq_pkg::ST_PHASE:
            begin
                state_next = msq_pkg::ST_ROM;
            end
            msq_pkg::ST_ROM:
            begin
                state_next = msq_pkg::ST_MUL;
            end
            msq_pkg::ST_MUL:
            begin
                mul_en     = 1'b1;
                state_next = msq_pkg::ST_ACC;
            end
            msq_pkg::ST_ACC:
            begin
                state_next = slot_last ? msq_pkg::ST_QPREP : msq_pkg::ST_PHASE;
            end
            msq_pkg::ST_QPREP:
            begin
                state_next = msq_pkg::ST_QMUL;
            end
            msq_pkg::ST_QMUL:
            begin
                mul_en     = 1'b1;
                mul_a      = AW'(shifted_reg);
                mul_b      = BW'($signed({1'b0, lv_eff}));
                state_next = msq_pkg::ST_QSTART;
            end
            msq_pkg::ST_QSTART:
            begin
                div_start  = 1'b1;
                state_next = msq_pkg::ST_QDIV;
            end
            msq_pkg::ST_QDIV:
            begin
                if (div_status.done)
                begin
                    state_next = msq_pkg::ST_DONE;
                end
            end
            msq_pkg::ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    load_out   = 1'b1;
                    state_next = msq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = msq_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------- control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int g = 0; g < MAX_HARMONICS; g++)
            begin
                acc_reg[g] <= '0;
            end
        end
        else
        begin
            if (accept)
            begin
                slot_reg <= '0;
                if (restart)
                begin
                    for (int g = 0; g < MAX_HARMONICS; g++)
                    begin
                        acc_reg[g] <= '0;
                    end
                end
            end
            else if (state_reg == msq_pkg::ST_PHASE)
            begin
                acc_reg[slot_reg] <= acc_reg[slot_reg] + inc;
            end
            else if (state_reg == msq_pkg::ST_ACC)
            begin
                slot_reg <= slot_last ? '0 : slot_reg + 1'b1;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sum_reg  <= '0;
            last_reg <= s_axis_tlast;
        end
        if (state_reg == msq_pkg::ST_PHASE)
        begin
            rom_addr_reg <= rom_addr_next;
            neg_reg      <= sidx[QW+1];
        end
        if ((state_reg == msq_pkg::ST_ACC) && slot_active)
        begin
            sum_reg <= sum_reg + term;
        end
        if (state_reg == msq_pkg::ST_QPREP)
        begin
            shifted_reg <= {sum_reg[SW-1], sum_reg} + $signed({2'b00, fs_eff});
        end
        if (load_out)
        begin
            out_sample_reg <= sum_reg;
            out_level_reg  <= level;
            out_last_reg   <= last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(msq_pkg::OUT_DATA_W - SW - LW)'(0), out_level_reg, out_sample_reg};
    assign m_axis_tlast  = out_last_reg;

    // ------------------------------------------------------------- assertions
    `MSQ_ASSERT_IMPL(a_ready_div_idle, s_axis_tready, !div_status.busy)
    `MSQ_ASSERT_NEXT(a_accept_drops_ready, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `MSQ_ASSERT_IMPL(a_div_done_waited, div_status.done, state_reg == msq_pkg::ST_QDIV)
    `MSQ_ASSERT_IMPL(a_level_in_range, m_axis_tvalid && (lv_eff >= QLW'(2)), QLW'(out_level_reg) < lv_eff)

endmodule

// ===== sim/multitone_synth_quantizer_test.sv =====
`timescale 1ns / 100ps

module multitone_synth_quantizer_test;

    import msq_pkg::*;

    localparam int TONES          = MAX_HARMONICS_DEF;
    localparam int SINE_BITS      = SINE_TABLE_BITS_DEF;
    localparam int SINE_ENTRIES   = 1 << SINE_BITS;
    localparam int QUARTER        = SINE_ENTRIES / 4;
    localparam logic [63:0] UNIT_Q30         = 64'd1 << 30;
    localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
    localparam int RANDOM_ITEMS   = 1800;
    localparam int SETTLE_CYCLES  = 4 * TONES + 24;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int MAX_PRINTS     = 50;

    typedef enum int {
        READY_ALWAYS,
        READY_RANDOM,
        READY_BURSTY
    } ready_mode_t;

    class tone_scoreboard;
        typedef struct {
            logic [SAMPLE_W-1:0] sample;
            logic [LEVEL_W-1:0]  level;
            logic                last;
        } tone_result_t;

        int                 sine_lut [SINE_ENTRIES];
        logic [COUNT_W-1:0] harmonic_count;
        logic [63:0]        harmonic_word [TONES];
        logic [FS_W-1:0]    full_scale;
        logic [QL_W-1:0]    quant_levels;
        logic [31:0]        phase_acc [TONES];
        tone_result_t       expected_q [$];
        int                 error_count;
        int                 checked_count;
        int                 restart_count;
        int                 clamp_count;

        function new();
            int k;
            int quad;
            int j;
            int v;
            for (k = 0; k < SINE_ENTRIES; k++)
            begin
                quad = k / QUARTER;
                j = k % QUARTER;
                v = (quad & 1) ? quarter_wave(QUARTER - j) : quarter_wave(j);
                sine_lut[k] = (quad & 2) ? -v : v;
            end
            harmonic_count = '0;
            full_scale = FS_RESET;
            quant_levels = QL_RESET;
            for (k = 0; k < TONES; k++)
            begin
                harmonic_word[k] = '0;
                phase_acc[k] = '0;
            end
            error_count = 0;
            checked_count = 0;
            restart_count = 0;
            clamp_count = 0;
        endfunction

        // Taylor series of sin through x^13 in Q2.30, Horner form, each term truncated.
        function int quarter_wave(int unsigned j);
            logic [63:0] ang;
            logic [63:0] ang_sq;
            logic [63:0] poly;
            logic [63:0] s;
            logic [63:0] v;
            int m;
            ang = (QUARTER_TURN_Q30 * j) / QUARTER;
            ang_sq = (ang * ang) >> 30;
            poly = UNIT_Q30;
            for (m = 6; m >= 1; m--)
            begin
                poly = UNIT_Q30 - ((ang_sq * poly) >> 30) / (2 * m * (2 * m + 1));
            end
            s = (ang * poly) >> 30;
            v = (s * 32767 + (64'd1 << 29)) >> 30;
            if (v > 32767)
            begin
                v = 32767;
            end
            return int'(v);
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            case (index)
                REG_HARMONIC_COUNT:  harmonic_count = value[COUNT_W-1:0];
                REG_HARMONIC_WORD_0: harmonic_word[0] = value;
                REG_HARMONIC_WORD_1: harmonic_word[1] = value;
                REG_HARMONIC_WORD_2: harmonic_word[2] = value;
                REG_HARMONIC_WORD_3: harmonic_word[3] = value;
                REG_FULL_SCALE:      full_scale = value[FS_W-1:0];
                REG_QUANT_LEVELS:    quant_levels = value[QL_W-1:0];
                default:             ;
            endcase
        endfunction

        // Predict the sample for one accepted request and queue it.
        function void note_request(logic restart, logic final_req);
            tone_result_t res;
            longint sum;
            longint product;
            longint shifted;
            longint fs;
            longint lv;
            longint level;
            logic [31:0] angle;
            int active;
            int i;
            if (restart)
            begin
                for (i = 0; i < TONES; i++)
                begin
                    phase_acc[i] = '0;
                end
                restart_count++;
            end
            active = (harmonic_count > TONES) ? TONES : harmonic_count;
            sum = 0;
            for (i = 0; i < active; i++)
            begin
                angle = phase_acc[i] + {harmonic_word[i][15:0], 16'h0000};
                product = longint'(harmonic_word[i][63:48]) * sine_lut[angle[31:32-SINE_BITS]];
                sum += product >>> PROD_FRAC;
            end
            // every accumulator advances, summed or not
            for (i = 0; i < TONES; i++)
            begin
                phase_acc[i] = phase_acc[i] + harmonic_word[i][47:16];
            end
            fs = (full_scale == 0) ? 1 : full_scale;
            lv = (quant_levels > QL_MAX) ? QL_MAX : quant_levels;
            level = 0;
            if (lv >= 2)
            begin
                shifted = sum + fs;
                if (shifted > 0)
                begin
                    level = (shifted * lv) / (2 * fs);
                    if (level > lv - 1)
                    begin
                        level = lv - 1;
                        clamp_count++;
                    end
                end
                else
                begin
                    clamp_count++;
                end
            end
            res.sample = sum[SAMPLE_W-1:0];
            res.level = level[LEVEL_W-1:0];
            res.last = final_req;
            expected_q.push_back(res);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report_mismatch(string msg);
            if (error_count < MAX_PRINTS)
            begin
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            end
            error_count++;
        endtask

        task check_sample(logic [OUT_DATA_W-1:0] data, logic last_flag);
            tone_result_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("sample with none expected, tdata=%h", data));
                return;
            end
            want = expected_q.pop_front();
            checked_count++;
            if (data[SAMPLE_W-1:0] !== want.sample)
            begin
                report_mismatch($sformatf("sample #%0d: analog got %h want %h",
                    checked_count, data[SAMPLE_W-1:0], want.sample));
            end
            if (data[SAMPLE_W+LEVEL_W-1:SAMPLE_W] !== want.level)
            begin
                report_mismatch($sformatf("sample #%0d: level got %0d want %0d",
                    checked_count, data[SAMPLE_W+LEVEL_W-1:SAMPLE_W], want.level));
            end
            if (last_flag !== want.last)
            begin
                report_mismatch($sformatf("sample #%0d: tlast got %b want %b",
                    checked_count, last_flag, want.last));
            end
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;   // [0] restart
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;        // [18:0] analog_sample, [26:19] quant_level
    logic                   m_axis_tlast;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    tone_scoreboard sb;
    ready_mode_t    ready_mode = READY_ALWAYS;
    bit             bursty_sender = 1'b0;
    int             cycle_count = 0;
    int             setting_count = 0;
    int             flag_seq = 0;
    int             ready_run = 0;
    bit             ready_state = 1'b1;

    logic [COUNT_W-1:0] plan_count;
    logic [63:0]        plan_word [TONES];
    logic [FS_W-1:0]    plan_fs;
    logic [QL_W-1:0]    plan_ql;

    multitone_synth_quantizer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d samples outstanding", cycle_count,
                sb.pending());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Output side: check accepted samples, stall on the current pattern.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_sample(m_axis_tdata, m_axis_tlast);
        end
        if (ready_run > 0)
        begin
            ready_run--;
        end
        else
        begin
            case (ready_mode)
                READY_ALWAYS: ready_state = 1'b1;
                READY_RANDOM: ready_state = 1'($urandom_range(0, 1));
                default:
                begin
                    ready_state = !ready_state;
                    ready_run = ready_state ? $urandom_range(0, 8) : $urandom_range(1, 30);
                end
            endcase
        end
        m_axis_tready <= ready_state;
    end

    function logic [63:0] pack_word(logic [15:0] amp, logic [31:0] inc, logic [15:0] offset);
        return {amp, inc, offset};
    endfunction

    task write_register(input logic [CFG_INDEX_W-1:0] index, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        sb.set_register(index, value);
        @(posedge clk);
    endtask

    // Write every register from the plan; junk above each narrow register must be masked.
    task apply_plan();
        logic [CFG_DATA_W-1:0] junk;
        logic [CFG_INDEX_W-1:0] idx;
        int i;
        junk = {$urandom, $urandom};
        write_register(REG_HARMONIC_COUNT, {junk[63:COUNT_W], plan_count});
        for (i = 0; i < TONES; i++)
        begin
            idx = CFG_INDEX_W'(int'(REG_HARMONIC_WORD_0) + i);
            write_register(idx, plan_word[i]);
        end
        junk = {$urandom, $urandom};
        write_register(REG_FULL_SCALE, {junk[63:FS_W], plan_fs});
        junk = {$urandom, $urandom};
        write_register(REG_QUANT_LEVELS, {junk[63:QL_W], plan_ql});
        if ($urandom_range(0, 3) == 0)
        begin
            write_register(REG_UNUSED, {$urandom, $urandom});
        end
        cfg_wr_en <= 1'b0;
        setting_count++;
        @(posedge clk);
    endtask

    task send_request(input logic restart, input logic final_req);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_DATA_W-1){1'b0}}, restart};
        s_axis_tlast <= final_req;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        sb.note_request(restart, final_req);
    endtask

    task send_items(input int count, input bit fixed_flags);
        int burst_left;
        int gap;
        int k;
        logic rs;
        logic fin;
        burst_left = 0;
        for (k = 0; k < count; k++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap = bursty_sender ? $urandom_range(0, 15) : 0;
                if (gap > 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            if (fixed_flags)
            begin
                rs = flag_seq[0];
                fin = flag_seq[1];
                flag_seq++;
            end
            else
            begin
                rs = ($urandom_range(0, 9) == 0);
                fin = ($urandom_range(0, 7) == 0) || (k == count - 1);
            end
            send_request(rs, fin);
            burst_left--;
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // Wait for every predicted sample, then let the block settle.
    task drain();
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task run_phase(input int count, input bit fixed_flags);
        apply_plan();
        send_items(count, fixed_flags);
        drain();
    endtask

    task randomize_plan();
        int total_amp;
        int lo;
        int hi;
        int i;
        logic [15:0] amp;
        logic [31:0] inc;
        plan_count = ($urandom_range(0, 5) == 0) ? COUNT_W'($urandom_range(0, 7))
                                                 : COUNT_W'($urandom_range(1, 4));
        total_amp = 0;
        for (i = 0; i < TONES; i++)
        begin
            case ($urandom_range(0, 7))
                0:       amp = 16'h0000;
                1:       amp = 16'hFFFF;
                2:       amp = 16'($urandom_range(0, 255));
                default: amp = 16'($urandom_range(0, 16'hFFFF));
            endcase
            case ($urandom_range(0, 7))
                0:       inc = 32'h0000_0000;
                1:       inc = 32'hFFFF_FFFF;
                2:       inc = $urandom_range(0, 1 << 22);
                default: inc = $urandom;
            endcase
            plan_word[i] = pack_word(amp, inc, 16'($urandom_range(0, 16'hFFFF)));
            if (i < plan_count)
            begin
                total_amp += amp;
            end
        end
        case ($urandom_range(0, 9))
            0:       plan_fs = '0;
            1:       plan_fs = 18'd1;
            2:       plan_fs = '1;
            3:       plan_fs = FS_W'($urandom_range(1, 18'h3FFFF));
            default:
            begin
                // keep the quantizer range near the signal swing so levels spread out
                lo = total_amp / 4 + 1;
                hi = total_amp + total_amp / 4 + 1;
                if (hi > 18'h3FFFF)
                begin
                    hi = 18'h3FFFF;
                end
                plan_fs = FS_W'($urandom_range(lo, hi));
            end
        endcase
        case ($urandom_range(0, 11))
            0:       plan_ql = 9'd0;
            1:       plan_ql = 9'd1;
            2:       plan_ql = 9'd2;
            3:       plan_ql = 9'd256;
            4:       plan_ql = QL_W'($urandom_range(257, 511));
            default: plan_ql = QL_W'($urandom_range(2, 256));
        endcase
    endtask

    initial
    begin
        int sent;
        int n;
        int i;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: no harmonics, sample sits mid-scale
        send_items(3, 1'b1);
        drain();

        // single positive peak, smallest full scale, two levels
        plan_count = 3'd1;
        plan_word[0] = pack_word(16'hFFFF, 32'h0, 16'h4000);
        for (i = 1; i < TONES; i++)
        begin
            plan_word[i] = '0;
        end
        plan_fs = 18'd1;
        plan_ql = 9'd2;
        run_phase(3, 1'b1);

        // count above the harmonic limit, four negative peaks, widest full scale
        plan_count = 3'd7;
        for (i = 0; i < TONES; i++)
        begin
            plan_word[i] = pack_word(16'hFFFF, 32'h0, 16'hC000);
        end
        plan_fs = 18'h3FFFF;
        plan_ql = 9'd256;
        run_phase(3, 1'b1);

        // four positive peaks, zero full scale, levels above the maximum
        plan_count = 3'd4;
        for (i = 0; i < TONES; i++)
        begin
            plan_word[i] = pack_word(16'hFFFF, 32'h0, 16'h4000);
        end
        plan_fs = '0;
        plan_ql = 9'd511;
        run_phase(3, 1'b1);

        // moving tones with zero and one level
        plan_count = 3'd5;
        for (i = 0; i < TONES; i++)
        begin
            plan_word[i] = pack_word(16'($urandom_range(0, 16'hFFFF)), $urandom, 16'h0000);
        end
        plan_fs = 18'd65536;
        plan_ql = 9'd0;
        run_phase(3, 1'b1);
        plan_ql = 9'd1;
        run_phase(3, 1'b1);

        // silent and half-scale tones at extreme increments
        plan_count = 3'd2;
        plan_word[0] = pack_word(16'h0000, 32'hFFFF_FFFF, 16'hFFFF);
        plan_word[1] = pack_word(16'h8000, 32'h8000_0000, 16'h0000);
        plan_word[2] = pack_word(16'hFFFF, 32'h1234_5678, 16'h8000);
        plan_word[3] = pack_word(16'hFFFF, 32'h0000_0001, 16'h7FFF);
        plan_fs = 18'd200;
        plan_ql = 9'd3;
        run_phase(4, 1'b1);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            randomize_plan();
            bursty_sender = ($urandom_range(0, 3) != 0);
            ready_mode = ready_mode_t'($urandom_range(0, 2));
            n = $urandom_range(20, 90);
            run_phase(n, 1'b0);
            sent += n;
        end

        drain();
        $display("Checked %0d samples over %0d register settings.", sb.checked_count,
            setting_count);
        $display("Requests with restart: %0d, quantizer clamps: %0d.", sb.restart_count,
            sb.clamp_count);
        if (sb.error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/msq_pkg.sv
hdl/msq_sine_rom.sv
hdl/msq_mul.sv
hdl/msq_qdiv.sv
hdl/multitone_synth_quantizer.sv
sim/multitone_synth_quantizer_test.sv
